// ----- rtl/rpb_pkg.sv -----
package rpb_pkg;

    // one pixel: [0] red, [1] green, [2] blue, [3] alpha
    typedef logic [3:0][7:0] pix_t;

    typedef enum logic [3:0] {
        MODE_REPLACE  = 4'd0,
        MODE_OVER     = 4'd1,
        MODE_UNDER    = 4'd2,
        MODE_PLUS     = 4'd3,
        MODE_MINUS    = 4'd4,
        MODE_ADD      = 4'd5,
        MODE_SUBTRACT = 4'd6,
        MODE_DIFF     = 4'd7,
        MODE_BUMP     = 4'd8,
        MODE_MAP      = 4'd9,
        MODE_MIX      = 4'd10,
        MODE_MULT     = 4'd11,
        MODE_LUM      = 4'd12,
        MODE_LUMINV   = 4'd13,
        MODE_COLORIZE = 4'd14
    } mode_t;

    typedef enum logic [1:0] {
        REG_BLEND_MODE = 2'd0,
        REG_USE_FILL   = 2'd1,
        REG_FILL_COLOR = 2'd2
    } reg_idx_t;

    // carried alongside the divider
    typedef struct packed {
        logic       is_over;
        logic [7:0] aout;
        pix_t       res;
    } aux_t;

    localparam int DIV_STAGES   = 4;
    localparam int DIV_PER_STEP = 2;

    localparam logic [7:0]  CH_MAX     = 8'd255;
    localparam logic [9:0]  RECIP3     = 10'd683;
    localparam logic [17:0] LUMA_R     = 18'd218;
    localparam logic [17:0] LUMA_G     = 18'd732;
    localparam logic [17:0] LUMA_B     = 18'd74;
    localparam logic [16:0] ROUND_HALF = 17'd128;

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? CH_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- rtl/rpb_front.sv -----
module rpb_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  rpb_pkg::pix_t            in_base,
    input  rpb_pkg::pix_t            in_over,
    input  rpb_pkg::mode_t           in_mode,
    output logic                     out_valid,
    output logic [2:0][15:0]         out_num,
    output rpb_pkg::aux_t            out_aux
);

    // stage 1: capture
    logic           v1_reg;
    rpb_pkg::pix_t  b1_reg, o1_reg;
    rpb_pkg::mode_t m1_reg;

    // stage 2: simple modes, luma sum product, colorize luma
    logic           v2_reg;
    rpb_pkg::pix_t  b2_reg, o2_reg, res2_reg, res2_next;
    rpb_pkg::mode_t m2_reg;
    logic [19:0]    lum2_reg;
    logic [17:0]    y2_reg;
    logic [15:0]    map2_reg;

    // stage 3: select top and bottom, (255-ta)*bottom alpha
    logic           v3_reg;
    rpb_pkg::pix_t  res3_reg, res3_next, top3_reg, bot3_reg, top3_next, bot3_next;
    logic [7:0]     ta3_reg, ta3_next;
    logic [15:0]    pa3_reg;
    logic           ov3_reg, ov3_next;

    // stage 4: output alpha
    logic           v4_reg;
    rpb_pkg::pix_t  res4_reg, top4_reg, bot4_reg;
    logic [7:0]     ta4_reg, aout4_reg, amul4_reg, aout4_next;
    logic           ov4_reg;

    // stage 5: numerators
    logic           v5_reg;
    logic [2:0][15:0] num5_reg, num5_next;
    rpb_pkg::aux_t  aux5_reg;

    logic [9:0]     lsum;
    logic [7:0]     lum3;
    logic [16:0]    mprod;

    always_comb
    begin
        lsum = {2'd0, o1_reg[0]} + {2'd0, o1_reg[1]} + {2'd0, o1_reg[2]};
        for (int c = 0; c < 4; c++)
        begin
            mprod = 17'(16'(b1_reg[c]) * 16'(o1_reg[c])) + rpb_pkg::ROUND_HALF;
            unique case (m1_reg)
                rpb_pkg::MODE_REPLACE:  res2_next[c] = o1_reg[c];
                rpb_pkg::MODE_OVER,
                rpb_pkg::MODE_UNDER,
                rpb_pkg::MODE_LUM,
                rpb_pkg::MODE_LUMINV:   res2_next[c] = 8'd0;
                rpb_pkg::MODE_PLUS:     res2_next[c] = rpb_pkg::sat_add8(b1_reg[c], o1_reg[c]);
                rpb_pkg::MODE_MINUS:    res2_next[c] = rpb_pkg::sat_sub8(b1_reg[c], o1_reg[c]);
                rpb_pkg::MODE_ADD:      res2_next[c] = (c == 3) ? b1_reg[c] + o1_reg[c]
                                            : rpb_pkg::sat_add8(b1_reg[c], o1_reg[c]);
                rpb_pkg::MODE_SUBTRACT: res2_next[c] = (c == 3) ? b1_reg[c] - o1_reg[c]
                                            : rpb_pkg::sat_sub8(b1_reg[c], o1_reg[c]);
                rpb_pkg::MODE_DIFF:     res2_next[c] = rpb_pkg::abs_diff8(b1_reg[c], o1_reg[c]);
                rpb_pkg::MODE_BUMP,
                rpb_pkg::MODE_MAP,
                rpb_pkg::MODE_COLORIZE: res2_next[c] = (c == 3) ? b1_reg[c] : o1_reg[c];
                rpb_pkg::MODE_MIX:      res2_next[c] = 8'(({1'b0, b1_reg[c]} + {1'b0, o1_reg[c]}) >> 1);
                rpb_pkg::MODE_MULT:     res2_next[c] = mprod[15:8];
                default:                res2_next[c] = b1_reg[c];
            endcase
        end
    end

    always_comb
    begin
        lum3      = lum2_reg[18:11];
        res3_next = res2_reg;
        top3_next = o2_reg;
        bot3_next = b2_reg;
        ta3_next  = o2_reg[3];
        ov3_next  = 1'b0;
        unique case (m2_reg)
            rpb_pkg::MODE_OVER:
            begin
                ov3_next = 1'b1;
            end
            rpb_pkg::MODE_UNDER:
            begin
                ov3_next  = 1'b1;
                top3_next = b2_reg;
                bot3_next = o2_reg;
                ta3_next  = b2_reg[3];
            end
            rpb_pkg::MODE_LUM:
            begin
                ov3_next = 1'b1;
                ta3_next = lum3;
            end
            rpb_pkg::MODE_LUMINV:
            begin
                ov3_next = 1'b1;
                ta3_next = rpb_pkg::CH_MAX - lum3;
            end
            rpb_pkg::MODE_MAP:
            begin
                res3_next[3] = rpb_pkg::div255(map2_reg);
            end
            rpb_pkg::MODE_COLORIZE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    res3_next[c] = 8'((26'(y2_reg) * 26'(o2_reg[c])) >> 18);
                end
            end
            default:
            begin
                res3_next = res2_reg;
            end
        endcase
    end

    assign aout4_next = ta3_reg + rpb_pkg::div255(pa3_reg);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num5_next[c] = 16'(ta4_reg) * 16'(top4_reg[c]) + 16'(amul4_reg) * 16'(bot4_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg   <= in_base;
        o1_reg   <= in_over;
        m1_reg   <= in_mode;

        b2_reg   <= b1_reg;
        o2_reg   <= o1_reg;
        m2_reg   <= m1_reg;
        res2_reg <= res2_next;
        lum2_reg <= 20'(lsum * rpb_pkg::RECIP3);
        y2_reg   <= rpb_pkg::LUMA_R * 18'(b1_reg[0]) + rpb_pkg::LUMA_G * 18'(b1_reg[1])
                    + rpb_pkg::LUMA_B * 18'(b1_reg[2]);
        map2_reg <= 16'(b1_reg[3]) * 16'(o1_reg[3]);

        res3_reg <= res3_next;
        top3_reg <= top3_next;
        bot3_reg <= bot3_next;
        ta3_reg  <= ta3_next;
        ov3_reg  <= ov3_next;
        pa3_reg  <= 16'(rpb_pkg::CH_MAX - ta3_next) * 16'(bot3_next[3]);

        res4_reg  <= res3_reg;
        top4_reg  <= top3_reg;
        bot4_reg  <= bot3_reg;
        ta4_reg   <= ta3_reg;
        ov4_reg   <= ov3_reg;
        aout4_reg <= aout4_next;
        amul4_reg <= aout4_next - ta3_reg;

        num5_reg         <= num5_next;
        aux5_reg.is_over <= ov4_reg;
        aux5_reg.aout    <= aout4_reg;
        aux5_reg.res     <= res4_reg;
    end

    assign out_valid = v5_reg;
    assign out_num   = num5_reg;
    assign out_aux   = aux5_reg;

endmodule

// ----- rtl/rpb_div.sv -----
module rpb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0][15:0]    in_num,
    input  rpb_pkg::aux_t       in_aux,
    output logic                out_valid,
    output logic [2:0][7:0]     out_quo,
    output rpb_pkg::aux_t       out_aux
);

    localparam int NS = rpb_pkg::DIV_STAGES;

    logic               v_reg   [NS];
    logic [2:0][15:0]   rem_reg [NS];
    logic [2:0][7:0]    q_reg   [NS];
    rpb_pkg::aux_t      aux_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic             v_src;
        logic [2:0][15:0] rem_src, rem_next;
        logic [2:0][7:0]  q_src, q_next;
        rpb_pkg::aux_t    aux_src;

        if (k == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign rem_src = in_num;
            assign q_src   = '0;
            assign aux_src = in_aux;
        end
        else
        begin : g_next
            assign v_src   = v_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign q_src   = q_reg[k-1];
            assign aux_src = aux_reg[k-1];
        end

        // two restoring steps per stage, most significant quotient bits first
        always_comb
        begin
            logic [15:0] sh;
            rem_next = rem_src;
            q_next   = q_src;
            for (int ln = 0; ln < 3; ln++)
            begin
                for (int j = 0; j < rpb_pkg::DIV_PER_STEP; j++)
                begin
                    sh = {8'd0, aux_src.aout} << (7 - rpb_pkg::DIV_PER_STEP * k - j);
                    if (rem_next[ln] >= sh)
                    begin
                        rem_next[ln] = rem_next[ln] - sh;
                        q_next[ln][7 - rpb_pkg::DIV_PER_STEP * k - j] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            q_reg[k]   <= q_next;
            aux_reg[k] <= aux_src;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_quo   = q_reg[NS-1];
    assign out_aux   = aux_reg[NS-1];

endmodule

// ----- rtl/rgba_pixel_blend_unit.sv -----
// channel    | direction | handshake               | payload
// -----------+-----------+-------------------------+------------------------------------
// pixel in   | in        | start high, busy low    | base_red/green/blue/alpha, over_*
// result out | out       | done strobe, one cycle  | out_red, out_green, out_blue, out_alpha
// config     | in        | cfg_valid and cfg_ready | cfg_index, cfg_data
//
// one pixel per clock; results leave in the order of their transactions
// the pipeline is five front stages, four divider stages (two quotient bits
// each) that every mode passes through, and the output register
// busy is held low and cfg_ready high: the pipeline never stalls
// rst_n clears the valid bits and the configuration registers
// the receiver cannot stall, so results leave on done regardless
module rgba_pixel_blend_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  base_red,
    input  logic [7:0]  base_green,
    input  logic [7:0]  base_blue,
    input  logic [7:0]  base_alpha,
    input  logic [7:0]  over_red,
    input  logic [7:0]  over_green,
    input  logic [7:0]  over_blue,
    input  logic [7:0]  over_alpha,
    output logic        done,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    rpb_pkg::mode_t mode_reg;
    logic           use_fill_reg;
    logic [31:0]    fill_reg;

    rpb_pkg::pix_t  base_pix, over_pix;

    logic             f_valid;
    logic [2:0][15:0] f_num;
    rpb_pkg::aux_t    f_aux;

    logic             d_valid;
    logic [2:0][7:0]  d_quo;
    rpb_pkg::aux_t    d_aux;

    logic             done_reg;
    rpb_pkg::pix_t    res_reg, res_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rpb_pkg::MODE_REPLACE;
            use_fill_reg <= 1'b0;
            fill_reg     <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rpb_pkg::REG_BLEND_MODE: mode_reg     <= rpb_pkg::mode_t'(cfg_data[3:0]);
                rpb_pkg::REG_USE_FILL:   use_fill_reg <= cfg_data[0];
                rpb_pkg::REG_FILL_COLOR: fill_reg     <= cfg_data;
                default:                 ;  // index beyond the register list
            endcase
        end
    end

    // pixel assembly; fill colour replaces the overlay fields when enabled
    assign base_pix = {base_alpha, base_blue, base_green, base_red};
    assign over_pix = use_fill_reg
                    ? {fill_reg[31:24], fill_reg[7:0], fill_reg[15:8], fill_reg[23:16]}
                    : {over_alpha, over_blue, over_green, over_red};

    rpb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_base   (base_pix),
        .in_over   (over_pix),
        .in_mode   (mode_reg),
        .out_valid (f_valid),
        .out_num   (f_num),
        .out_aux   (f_aux)
    );

    rpb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_num    (f_num),
        .in_aux    (f_aux),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_aux   (d_aux)
    );

    // over-type modes take the quotients; zero output alpha gives black
    always_comb
    begin
        if (d_aux.is_over)
        begin
            for (int c = 0; c < 3; c++)
            begin
                res_next[c] = (d_aux.aout == 8'd0) ? 8'd0 : d_quo[c];
            end
            res_next[3] = d_aux.aout;
        end
        else
        begin
            res_next = d_aux.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done      = done_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = res_reg[3];

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } rgba_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  base_red, base_green, base_blue, base_alpha;
    logic [7:0]  over_red, over_green, over_blue, over_alpha;
    logic        done;
    logic [7:0]  out_red, out_green, out_blue, out_alpha;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow copy of the configuration registers
    logic [3:0]  cur_mode;
    logic        cur_use_fill;
    logic [31:0] cur_fill;

    rgba_t  blend_expect_q[$];
    int     mismatch_count;
    int     unexpected_count;
    int     cycle_count;
    int     sender_idle_pct;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 30;

    rgba_pixel_blend_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .base_red   (base_red),
        .base_green (base_green),
        .base_blue  (base_blue),
        .base_alpha (base_alpha),
        .over_red   (over_red),
        .over_green (over_green),
        .over_blue  (over_blue),
        .over_alpha (over_alpha),
        .done       (done),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter doubles as the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // over-type compositing: top pixel with alpha ta over the bottom pixel
    function automatic rgba_t composite_over(rgba_t bot, rgba_t top, logic [7:0] ta);
        int    aout;
        int    amul;
        int    v;
        int    tc[3];
        int    bc[3];
        rgba_t res;
        aout = ta + ((255 - ta) * bot.a) / 255;
        amul = aout - ta;
        tc = '{top.r, top.g, top.b};
        bc = '{bot.r, bot.g, bot.b};
        for (int c = 0; c < 3; c++)
        begin
            v = 0;
            if (aout != 0)
            begin
                v = (ta * tc[c] + amul * bc[c]) / aout;
                if (v > 255) v = 255;
            end
            tc[c] = v;
        end
        res.r = tc[0][7:0];
        res.g = tc[1][7:0];
        res.b = tc[2][7:0];
        res.a = (aout > 255) ? 8'd255 : aout[7:0];
        return res;
    endfunction

    function automatic int sat_sum(int x, int y);
        return (x + y > 255) ? 255 : x + y;
    endfunction

    function automatic int sat_diff(int x, int y);
        return (x > y) ? x - y : 0;
    endfunction

    function automatic int abs_gap(int x, int y);
        return (x > y) ? x - y : y - x;
    endfunction

    // work out the blended pixel for one base/overlay pair
    function automatic rgba_t blended_pixel(rgba_t bp, rgba_t op_in);
        rgba_t op;
        rgba_t res;
        int    bv[4];
        int    ov[4];
        int    rv[4];
        int    lum;
        int    luma_y;
        op = cur_use_fill ? rgba_t'({cur_fill[23:16], cur_fill[15:8], cur_fill[7:0],
                                     cur_fill[31:24]}) : op_in;
        bv = '{bp.r, bp.g, bp.b, bp.a};
        ov = '{op.r, op.g, op.b, op.a};
        rv = bv;
        case (cur_mode)
            rpb_pkg::MODE_REPLACE:  rv = ov;
            rpb_pkg::MODE_OVER:     return composite_over(bp, op, op.a);
            rpb_pkg::MODE_UNDER:    return composite_over(op, bp, bp.a);
            rpb_pkg::MODE_PLUS:     for (int c = 0; c < 4; c++) rv[c] = sat_sum(bv[c], ov[c]);
            rpb_pkg::MODE_MINUS:    for (int c = 0; c < 4; c++) rv[c] = sat_diff(bv[c], ov[c]);
            rpb_pkg::MODE_ADD:
            begin
                for (int c = 0; c < 3; c++) rv[c] = sat_sum(bv[c], ov[c]);
                rv[3] = (bv[3] + ov[3]) & 255;
            end
            rpb_pkg::MODE_SUBTRACT:
            begin
                for (int c = 0; c < 3; c++) rv[c] = sat_diff(bv[c], ov[c]);
                rv[3] = (bv[3] - ov[3]) & 255;
            end
            rpb_pkg::MODE_DIFF:     for (int c = 0; c < 4; c++) rv[c] = abs_gap(bv[c], ov[c]);
            rpb_pkg::MODE_BUMP:
            begin
                rv = ov;
                rv[3] = bv[3];
            end
            rpb_pkg::MODE_MAP:
            begin
                rv = ov;
                rv[3] = (bv[3] * ov[3]) / 255;
            end
            rpb_pkg::MODE_MIX:      for (int c = 0; c < 4; c++) rv[c] = (bv[c] + ov[c]) >> 1;
            rpb_pkg::MODE_MULT:
                for (int c = 0; c < 4; c++) rv[c] = (bv[c] * ov[c] + 128) >> 8;
            rpb_pkg::MODE_LUM:
            begin
                lum = (ov[0] + ov[1] + ov[2]) / 3;
                return composite_over(bp, op, lum[7:0]);
            end
            rpb_pkg::MODE_LUMINV:
            begin
                lum = 255 - (ov[0] + ov[1] + ov[2]) / 3;
                return composite_over(bp, op, lum[7:0]);
            end
            rpb_pkg::MODE_COLORIZE:
            begin
                luma_y = 218 * bv[0] + 732 * bv[1] + 74 * bv[2];
                for (int c = 0; c < 3; c++)
                    rv[c] = int'((longint'(luma_y) * ov[c]) >>> 18);
                rv[3] = bv[3];
            end
            default:       rv = bv;   // unused mode passes the base through
        endcase
        res.r = rv[0][7:0];
        res.g = rv[1][7:0];
        res.b = rv[2][7:0];
        res.a = rv[3][7:0];
        return res;
    endfunction

    // result checker: each done strobe is compared against the oldest prediction
    always @(posedge clk)
    begin
        rgba_t want;
        if (rst_n && done)
        begin
            if (blend_expect_q.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result %h %h %h %h", out_red, out_green,
                             out_blue, out_alpha);
            end
            else
            begin
                want = blend_expect_q.pop_front();
                if (want.r !== out_red || want.g !== out_green ||
                    want.b !== out_blue || want.a !== out_alpha)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("mismatch mode %0d: expected r%h g%h b%h a%h got r%h g%h b%h a%h",
                                 cur_mode, want.r, want.g, want.b, want.a,
                                 out_red, out_green, out_blue, out_alpha);
                end
            end
        end
    end

    // one pixel transaction; sender gaps drawn from sender_idle_pct
    // start stays high afterwards until the next gap or drain lowers it
    task automatic send_pixel(rgba_t bp, rgba_t op);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        base_red   <= bp.r;
        base_green <= bp.g;
        base_blue  <= bp.b;
        base_alpha <= bp.a;
        over_red   <= op.r;
        over_green <= op.g;
        over_blue  <= op.b;
        over_alpha <= op.a;
        @(posedge clk);
        while (busy) @(posedge clk);
        blend_expect_q.push_back(blended_pixel(bp, op));
    endtask

    // wait for every prediction to be matched, then let the pipe settle
    task automatic drain_pipe();
        start <= 1'b0;
        while (blend_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high for back-to-back writes; setup_blend lowers it
    task automatic write_reg(rpb_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            rpb_pkg::REG_BLEND_MODE: cur_mode     = value[3:0];
            rpb_pkg::REG_USE_FILL:   cur_use_fill = value[0];
            default:                 cur_fill     = value;
        endcase
    endtask

    task automatic setup_blend(logic [3:0] mode, logic use_fill, logic [31:0] fill);
        drain_pipe();
        write_reg(rpb_pkg::REG_BLEND_MODE, {28'd0, mode});
        write_reg(rpb_pkg::REG_USE_FILL, {31'd0, use_fill});
        write_reg(rpb_pkg::REG_FILL_COLOR, fill);
        cfg_valid <= 1'b0;
    endtask

    function automatic rgba_t rand_pixel();
        rgba_t p;
        p = $urandom;
        // bias towards the channel extremes now and then
        case ($urandom_range(7))
            0: p.a = 8'd0;
            1: p.a = 8'd255;
            2: p = '0;
            3: p = '1;
            default: ;
        endcase
        return p;
    endfunction

    // directed: every mode against corner pixels, incl. zero output alpha
    task automatic test_directed();
        rgba_t corners[5];
        corners = '{32'h00000000, 32'hffffffff, 32'hff00ff00, 32'h00ff00ff, 32'h80407f01};
        sender_idle_pct = 0;
        for (int m = 0; m < 16; m++)
        begin
            setup_blend(m[3:0], 1'b0, 32'h0);
            send_pixel(corners[0], corners[0]);   // zero alpha on both sides
            send_pixel(corners[1], corners[1]);
            send_pixel(corners[2], corners[3]);
            send_pixel(corners[3], corners[2]);
            send_pixel(corners[4], rand_pixel());
        end
        // fill colour overrides the overlay inputs
        setup_blend(rpb_pkg::MODE_OVER, 1'b1, 32'h80ff4000);
        send_pixel(corners[4], corners[1]);
        send_pixel(corners[1], corners[0]);
    endtask

    // random pixels under random modes and fill settings, per idling phase
    task automatic test_random(int idle_pct, int count);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                setup_blend(4'($urandom_range(15)), 1'($urandom_range(1)), $urandom);
            send_pixel(rand_pixel(), rand_pixel());
        end
    endtask

    // fill colour extremes
    task automatic test_fill_extremes();
        sender_idle_pct = 32;
        setup_blend(rpb_pkg::MODE_MULT, 1'b1, 32'hffffffff);
        repeat (10) send_pixel(rand_pixel(), rand_pixel());
        setup_blend(rpb_pkg::MODE_COLORIZE, 1'b1, 32'h00ffffff);
        repeat (10) send_pixel(rand_pixel(), rand_pixel());
        setup_blend(rpb_pkg::MODE_LUMINV, 1'b1, 32'h00000000);
        repeat (10) send_pixel(rand_pixel(), rand_pixel());
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rpb_pkg::REG_BLEND_MODE;
        cfg_data = '0;
        {base_red, base_green, base_blue, base_alpha} = '0;
        {over_red, over_green, over_blue, over_alpha} = '0;
        cur_mode = rpb_pkg::MODE_REPLACE;
        cur_use_fill = 1'b0;
        cur_fill = '0;
        mismatch_count = 0;
        unexpected_count = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(0, 300);
        test_random(73, 300);
        test_random(32, 240);
        test_fill_extremes();
        drain_pipe();

        if (mismatch_count == 0 && unexpected_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
